// File: sv/dwc_pkg.sv
// Package: shared constants and types for the waveform capture store.
`timescale 1ns / 1ps
package dwc_pkg;
	localparam int CHANNELS = 4;
	localparam int CAPACITY = 256;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;
	localparam int ADDR_W = CH_W + IDX_W;
	localparam int MEM_W = 33;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_CH = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_ACTIVE = 1'b1;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [47:0] last_t;
		logic [47:0] period;
		logic signed [31:0] vmin;
		logic signed [31:0] vmax;
	} chan_t;
endpackage

// File: sv/dwc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module dwc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: sv/dwc_div.sv
// Serial fraction divider: q = floor(t * 2^32 / dt), one bit a cycle.
`timescale 1ns / 1ps
module dwc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [47:0] num,
	input logic [47:0] den,
	output logic done,
	output logic [31:0] quo
);
	logic [48:0] r_q;
	logic [47:0] d_q;
	logic [5:0] n_q;
	logic busy_q;
	logic [49:0] sh;
	always_comb sh = {r_q, 1'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= '0;
			end else if (busy_q) begin
				n_q <= n_q + 6'd1;
				if (n_q == 6'd31) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= {1'b0, num};
			d_q <= den;
			quo <= '0;
		end else if (busy_q) begin
			if (sh >= {2'b0, d_q}) begin
				r_q <= 49'(sh - {2'b0, d_q});
				quo <= {quo[30:0], 1'b1};
			end else begin
				r_q <= sh[48:0];
				quo <= {quo[30:0], 1'b0};
			end
		end
	end
endmodule

// File: sv/decimating_waveform_capture.sv
// Top level: multi-channel decimating waveform capture store.
// Bad channel, stale add, first add and read beyond count go straight to the result;
// a read fetches the point first; an interpolating add makes each point by serial divide,
// multiply, store write and loop check, with a compaction pass whenever the channel is full.
// One item at a time: the next item is accepted the cycle after its result issues.
// Reset clears channel state and config to defaults; point RAM is not cleared.
`timescale 1ns / 1ps
module decimating_waveform_capture
	import dwc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic opcode,
	input logic [1:0] channel,
	input logic [47:0] timestamp,
	input logic signed [31:0] sample_value,
	input logic continued,
	input logic [7:0] point_index,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic signed [31:0] point_value,
	output logic point_continued,
	output logic [8:0] point_count,
	output logic signed [31:0] min_seen,
	output logic signed [31:0] max_seen,
	output logic [47:0] sample_period,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_LAST = 4'd3,
		S_LASTW = 4'd4, S_LOOP = 4'd5, S_DIV = 4'd6, S_MUL = 4'd7, S_PUT = 4'd8,
		S_DEC = 4'd9, S_DECW = 4'd10, S_OUT = 4'd11, S_DECR = 4'd12;

	logic [3:0] st_q;
	logic [31:0] per_cfg_q;
	logic [2:0] act_q;
	chan_t ch_q [CHANNELS];
	chan_t cur;

	logic op_q, cont_q, pc_q;
	logic [CH_W-1:0] ch_sel_q;
	logic [47:0] ts_q, t_q, dt_q, base_q;
	logic signed [31:0] val_q, lastv_q, pv_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0] st_code_q;
	logic signed [32:0] dv_q;
	logic neg_q;
	logic [63:0] prod_q;
	logic [IDX_W:0] dec_i_q;
	logic [IDX_W-1:0] dec_k_q;

	logic we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [MEM_W-1:0] wdata, rdata;
	logic div_start, div_done;
	logic [31:0] quo;

	dwc_ram #(.WIDTH(MEM_W), .DEPTH(CHANNELS * CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);
	dwc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(t_q), .den(dt_q),
		.done(div_done), .quo(quo)
	);

	logic [2:0] limit;
	logic [32:0] mag;
	logic [31:0] off;
	logic signed [31:0] ipt;
	logic [48:0] tsum;
	always_comb begin
		cur = ch_q[ch_sel_q];
		limit = (act_q < 3'(CHANNELS)) ? act_q : 3'(CHANNELS);
		mag = neg_q ? 33'(-dv_q) : 33'(dv_q);
		off = prod_q[63:32];
		ipt = neg_q ? lastv_q - $signed(off) : lastv_q + $signed(off);
		tsum = {1'b0, t_q} + {1'b0, cur.period};
	end

	assign in_stall = (st_q != S_IDLE);
	assign cfg_ready = (st_q == S_IDLE) && !in_valid;
	assign div_start = (st_q == S_LOOP) && (t_q < dt_q) && (cur.cnt < CNT_W'(CAPACITY));

	always_comb begin
		we = 1'b0;
		waddr = {ch_sel_q, cur.cnt[IDX_W-1:0]};
		wdata = {cont_q, ipt};
		raddr = {ch_sel_q, idx_q};
		if (st_q == S_LAST || st_q == S_LASTW)
			raddr = {ch_sel_q, IDX_W'(cur.cnt - CNT_W'(1))};
		if (st_q == S_DEC || st_q == S_DECR || st_q == S_DECW)
			raddr = {ch_sel_q, dec_i_q[IDX_W-1:0]};
		if (st_q == S_PUT)
			we = 1'b1;
		if (st_q == S_RD && op_q == OP_ADD && st_code_q == ST_OK && cur.cnt == '0) begin
			we = 1'b1;
			waddr = {ch_sel_q, IDX_W'(0)};
			wdata = {cont_q, val_q};
		end
		if (st_q == S_DECW) begin
			we = 1'b1;
			waddr = {ch_sel_q, dec_k_q};
			wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			per_cfg_q <= 32'd1;
			act_q <= 3'd4;
			for (int i = 0; i < CHANNELS; i++)
				ch_q[i] <= '0;
		end else begin
			if (st_q == S_OUT && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PERIOD: per_cfg_q <= cfg_data;
					CFG_ACTIVE: act_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: if (in_valid) st_q <= S_RD;
				S_RD: begin
					if (st_code_q != ST_OK) st_q <= S_OUT;
					else if (op_q == OP_READ) begin
						if ({1'b0, idx_q} >= cur.cnt) st_q <= S_OUT;
						else st_q <= S_RDW;
					end else if (cur.cnt == '0) begin
						ch_q[ch_sel_q].cnt <= CNT_W'(1);
						ch_q[ch_sel_q].last_t <= ts_q;
						ch_q[ch_sel_q].period <= (per_cfg_q == '0) ? 48'd1 : 48'(per_cfg_q);
						ch_q[ch_sel_q].vmin <= val_q;
						ch_q[ch_sel_q].vmax <= val_q;
						st_q <= S_OUT;
					end else if (ts_q <= cur.last_t) st_q <= S_OUT;
					else begin
						if (cur.period == '0) ch_q[ch_sel_q].period <= 48'd1;
						st_q <= S_LAST;
					end
				end
				S_RDW: st_q <= S_OUT;
				S_LAST: st_q <= S_LASTW;
				S_LASTW: st_q <= S_LOOP;
				S_LOOP: begin
					if (t_q >= dt_q) st_q <= S_OUT;
					else if (cur.cnt >= CNT_W'(CAPACITY)) st_q <= S_DEC;
					else st_q <= S_DIV;
				end
				S_DIV: if (div_done) st_q <= S_MUL;
				S_MUL: st_q <= S_PUT;
				S_PUT: begin
					ch_q[ch_sel_q].cnt <= cur.cnt + CNT_W'(1);
					if (ipt < cur.vmin) ch_q[ch_sel_q].vmin <= ipt;
					if (ipt > cur.vmax) ch_q[ch_sel_q].vmax <= ipt;
					ch_q[ch_sel_q].last_t <= 48'(base_q + t_q);
					st_q <= S_LOOP;
				end
				S_DEC: st_q <= S_DECR;
				S_DECR: st_q <= S_DECW;
				S_DECW: begin
					if (dec_i_q + (IDX_W+1)'(2) >= (IDX_W+1)'(CAPACITY)) begin
						ch_q[ch_sel_q].cnt <= CNT_W'(dec_k_q) + CNT_W'(1);
						ch_q[ch_sel_q].period <= (cur.period > (MAX48 >> 1)) ? MAX48
							: {cur.period[46:0], 1'b0};
						st_q <= S_LOOP;
					end else st_q <= S_DEC;
				end
				S_OUT: if (!out_valid || !out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: if (in_valid) begin
				op_q <= opcode;
				ch_sel_q <= channel;
				ts_q <= timestamp;
				val_q <= sample_value;
				cont_q <= continued;
				idx_q <= point_index;
				pv_q <= '0;
				pc_q <= 1'b0;
				st_code_q <= ({1'b0, channel} >= limit) ? ST_BAD_CH : ST_OK;
			end
			S_RD: begin
				if (st_code_q == ST_OK) begin
					if (op_q == OP_READ && {1'b0, idx_q} >= cur.cnt)
						st_code_q <= ST_RANGE;
					if (op_q == OP_ADD && cur.cnt != '0 && ts_q <= cur.last_t)
						st_code_q <= ST_STALE;
				end
				base_q <= cur.last_t;
				dt_q <= 48'(ts_q - cur.last_t);
				t_q <= (cur.period == '0) ? 48'd1 : cur.period;
			end
			S_RDW: begin
				pv_q <= rdata[31:0];
				pc_q <= rdata[32];
			end
			S_LASTW: begin
				lastv_q <= rdata[31:0];
				dv_q <= 33'(val_q) - 33'($signed(rdata[31:0]));
				neg_q <= ($signed(val_q) < $signed(rdata[31:0]));
			end
			S_MUL: prod_q <= 64'(mag[31:0]) * 64'(quo) + ((mag[32]) ? {quo, 32'd0} : 64'd0);
			S_PUT: t_q <= tsum[48] ? MAX48 : tsum[47:0];
			S_LOOP: begin
				dec_i_q <= '0;
				dec_k_q <= '0;
			end
			S_DECW: begin
				dec_i_q <= dec_i_q + (IDX_W+1)'(2);
				dec_k_q <= dec_k_q + IDX_W'(1);
			end
			default: ;
		endcase
		if (st_q == S_PUT && tsum[48])
			dt_q <= '0;
		if (st_q == S_OUT && (!out_valid || !out_stall)) begin
			status <= st_code_q;
			point_value <= pv_q;
			point_continued <= pc_q;
			point_count <= (st_code_q == ST_BAD_CH) ? '0 : cur.cnt;
			min_seen <= (st_code_q == ST_BAD_CH) ? '0 : cur.vmin;
			max_seen <= (st_code_q == ST_BAD_CH) ? '0 : cur.vmax;
			sample_period <= (st_code_q == ST_BAD_CH) ? '0 : cur.period;
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> in_stall) else $error("stall low while busy");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> (cur.cnt <= CNT_W'(CAPACITY))) else $error("count beyond capacity");
	a_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> (st_q == S_IDLE)) else $error("cfg while busy");
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_PUT) |-> (ch_q[ch_sel_q].cnt < CNT_W'(CAPACITY)))
		else $error("write into full channel");
endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the decimating waveform capture store.
`timescale 1ns / 1ps
module tb_top;
	import dwc_pkg::*;

	typedef struct {
		logic op;
		logic [1:0] ch;
		logic [47:0] ts;
		logic signed [31:0] val;
		logic cont;
		logic [7:0] idx;
	} capture_req_t;

	typedef struct {
		logic [1:0] st;
		logic signed [31:0] pval;
		logic pcont;
		logic [8:0] cnt;
		logic signed [31:0] vmin;
		logic signed [31:0] vmax;
		logic [47:0] per;
	} capture_rsp_t;

	typedef struct {
		capture_req_t req;
		bit typed;
		capture_rsp_t rsp;
	} table_row_t;

	localparam longint LIMIT = 2000000;

	logic clk, arst_n;
	logic in_valid, in_stall, opcode, continued;
	logic [1:0] channel;
	logic [47:0] timestamp;
	logic signed [31:0] sample_value;
	logic [7:0] point_index;
	logic out_valid, out_stall, point_continued;
	logic [1:0] status;
	logic signed [31:0] point_value, min_seen, max_seen;
	logic [8:0] point_count;
	logic [47:0] sample_period;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [31:0] cfg_data;

	decimating_waveform_capture dut (.*);

	// predictor state
	logic [31:0] wave_val [CHANNELS*CAPACITY];
	bit wave_cont [CHANNELS*CAPACITY];
	int wave_cnt [CHANNELS];
	logic [47:0] wave_last [CHANNELS];
	logic [47:0] wave_per [CHANNELS];
	logic signed [31:0] wave_min [CHANNELS];
	logic signed [31:0] wave_max [CHANNELS];
	logic [31:0] first_period;
	logic [2:0] live_channels;

	capture_rsp_t pending_rsp [$];
	int errors, beats_out, adds_sent, reads_sent, decimations;
	longint cycles;
	bit calm;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] lerp(logic signed [31:0] last, longint dv,
			logic [63:0] t, logic [63:0] dt);
		logic [63:0] r, q, mag, off;
		r = t;
		q = 0;
		for (int i = 0; i < 32; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= dt) begin
				r = r - dt;
				q = q | 1;
			end
		end
		mag = dv < 0 ? -dv : dv;
		off = (mag >> 32) * q + (((mag & 64'hFFFF_FFFF) * q) >> 32);
		return dv < 0 ? last - off[31:0] : last + off[31:0];
	endfunction

	function automatic void append_point(int c, logic signed [31:0] v, bit f);
		if (wave_cnt[c] >= CAPACITY) begin
			int k;
			k = 0;
			for (int i = 0; i < wave_cnt[c]; i += 2) begin
				wave_val[c*CAPACITY+k] = wave_val[c*CAPACITY+i];
				wave_cont[c*CAPACITY+k] = wave_cont[c*CAPACITY+i];
				k++;
			end
			wave_cnt[c] = k;
			wave_per[c] = wave_per[c] > MAX48 / 2 ? MAX48 : wave_per[c] * 2;
			decimations++;
		end
		wave_val[c*CAPACITY+wave_cnt[c]] = v;
		wave_cont[c*CAPACITY+wave_cnt[c]] = f;
		wave_cnt[c]++;
		if (v < wave_min[c]) wave_min[c] = v;
		if (v > wave_max[c]) wave_max[c] = v;
	endfunction

	function automatic capture_rsp_t capture_step(capture_req_t r);
		capture_rsp_t o;
		int c, lim;
		logic [63:0] t, dt;
		logic [47:0] base;
		logic signed [31:0] lastv;
		longint dv;
		o = '{default: 0};
		c = r.ch;
		lim = live_channels < CHANNELS ? live_channels : CHANNELS;
		if (c >= lim) begin
			o.st = ST_BAD_CH;
			return o;
		end
		o.st = ST_OK;
		if (r.op == OP_ADD) begin
			if (wave_cnt[c] == 0) begin
				wave_per[c] = first_period != 0 ? {16'd0, first_period} : 48'd1;
				wave_last[c] = r.ts;
				wave_min[c] = r.val;
				wave_max[c] = r.val;
				append_point(c, r.val, r.cont);
			end else if (r.ts <= wave_last[c]) begin
				o.st = ST_STALE;
			end else begin
				base = wave_last[c];
				dt = r.ts - base;
				lastv = wave_val[c*CAPACITY+wave_cnt[c]-1];
				dv = longint'(r.val) - longint'(lastv);
				if (wave_per[c] == 0) wave_per[c] = 1;
				t = wave_per[c];
				while (t < dt) begin
					append_point(c, lerp(lastv, dv, t, dt), r.cont);
					wave_last[c] = base + t[47:0];
					t = t + wave_per[c];
				end
			end
		end else if (r.idx >= wave_cnt[c]) begin
			o.st = ST_RANGE;
		end else begin
			o.pval = wave_val[c*CAPACITY+r.idx];
			o.pcont = wave_cont[c*CAPACITY+r.idx];
		end
		o.cnt = wave_cnt[c];
		o.vmin = wave_min[c];
		o.vmax = wave_max[c];
		o.per = wave_per[c];
		return o;
	endfunction

	// issue one beat; called just after a rising edge, leaves valid high
	task automatic send_beat(capture_req_t r, bit typed, capture_rsp_t want);
		int gap;
		capture_rsp_t got;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		channel <= r.ch;
		timestamp <= r.ts;
		sample_value <= r.val;
		continued <= r.cont;
		point_index <= r.idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = capture_step(r);
		pending_rsp.insert(pending_rsp.size(), typed ? want : got);
		if (r.op == OP_ADD) adds_sent++;
		else reads_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_rsp.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_PERIOD) first_period = data;
		else live_channels = data[2:0];
	endtask

	function automatic capture_req_t random_req();
		capture_req_t r;
		int c;
		logic [63:0] span;
		r.op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ADD;
		r.ch = $urandom_range(0, 3);
		r.val = $urandom;
		r.cont = $urandom_range(0, 1);
		r.idx = $urandom;
		r.ts = {$urandom, $urandom};
		c = r.ch;
		if (r.op == OP_READ) begin
			if (wave_cnt[c] > 0 && $urandom_range(0, 3) != 0)
				r.idx = $urandom_range(0, wave_cnt[c] - 1);
		end else if (wave_cnt[c] > 0) begin
			span = wave_per[c] > 48'h0000_1000_0000 ? 64'h0000_8000_0000_0000
				: 64'(wave_per[c]) * 12;
			if ($urandom_range(0, 7) == 0)
				r.ts = wave_last[c] > 48'd3 ? wave_last[c] - $urandom_range(0, 3)
					: wave_last[c];
			else
				r.ts = wave_last[c] + 48'({$urandom, $urandom} % span) + 1;
			if ($urandom_range(0, 3) == 0)
				r.val = $signed(wave_val[c*CAPACITY+wave_cnt[c]-1]) + $signed($urandom_range(0, 2000)) - 1000;
		end
		return r;
	endfunction

	// result side: random stall, compare against oldest expectation
	int hold_left;
	always @(posedge clk) begin
		capture_rsp_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (out_valid && !out_stall) begin
				beats_out++;
				if (pending_rsp.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat, status %0d", status);
				end else begin
					e = pending_rsp.pop_front();
					if (e.st !== status || e.pval !== point_value || e.pcont !== point_continued
						|| e.cnt !== point_count || e.vmin !== min_seen || e.vmax !== max_seen
						|| e.per !== sample_period) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp st=%0d v=%h c=%b n=%0d mn=%h mx=%h p=%h got st=%0d v=%h c=%b n=%0d mn=%h mx=%h p=%h",
								e.st, e.pval, e.pcont, e.cnt, e.vmin, e.vmax, e.per,
								status, point_value, point_continued, point_count,
								min_seen, max_seen, sample_period);
					end
				end
				hold_left = calm ? 0 : $urandom_range(0, 8);
			end
			out_stall <= hold_left != 0;
			if (hold_left != 0) hold_left--;
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	table_row_t plan [$];

	function automatic capture_req_t mk(logic op, logic [1:0] ch, logic [47:0] ts,
			logic [31:0] v, logic f, logic [7:0] idx);
		capture_req_t r;
		r.op = op; r.ch = ch; r.ts = ts; r.val = v; r.cont = f; r.idx = idx;
		return r;
	endfunction

	function automatic capture_rsp_t rs(logic [1:0] st, logic [8:0] n, logic [31:0] mn,
			logic [31:0] mx, logic [47:0] p);
		capture_rsp_t o;
		o = '{default: 0};
		o.st = st; o.cnt = n; o.vmin = mn; o.vmax = mx; o.per = p;
		return o;
	endfunction

	initial begin
		capture_rsp_t nil;
		nil = '{default: 0};
		arst_n = 0;
		in_valid = 0; opcode = 0; channel = 0; timestamp = 0; sample_value = 0;
		continued = 0; point_index = 0; out_stall = 0; cfg_valid = 0; cfg_index = 0;
		cfg_data = 0;
		errors = 0; beats_out = 0; adds_sent = 0; reads_sent = 0; decimations = 0;
		cycles = 0; hold_left = 0; calm = 0;
		foreach (wave_cnt[i]) begin
			wave_cnt[i] = 0; wave_last[i] = 0; wave_per[i] = 0; wave_min[i] = 0; wave_max[i] = 0;
		end
		first_period = 1;
		live_channels = 4;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		plan.insert(plan.size(), '{mk(OP_READ, 0, 0, 0, 0, 0), 1, rs(ST_RANGE, 0, 0, 0, 0)});
		plan.insert(plan.size(), '{mk(OP_READ, 3, 0, 0, 0, 0), 1, rs(ST_BAD_CH, 0, 0, 0, 0)});
		plan.insert(plan.size(), '{mk(OP_ADD, 0, 100, 32'h7FFF_FFFF, 1, 0), 1,
			rs(ST_OK, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5)});
		plan.insert(plan.size(), '{mk(OP_ADD, 0, 100, 0, 0, 0), 1,
			rs(ST_STALE, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5)});
		plan.insert(plan.size(), '{mk(OP_ADD, 0, 130, 32'h8000_0000, 0, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_READ, 0, 0, 0, 0, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_READ, 0, 0, 0, 0, 5), 0, nil});
		plan.insert(plan.size(), '{mk(OP_READ, 0, 0, 0, 0, 8'hFF), 0, nil});
		plan.insert(plan.size(), '{mk(OP_ADD, 1, MAX48, 0, 0, 0), 1, rs(ST_OK, 1, 0, 0, 5)});
		plan.insert(plan.size(), '{mk(OP_ADD, 1, 0, 5, 1, 0), 1, rs(ST_STALE, 1, 0, 0, 5)});
		plan.insert(plan.size(), '{mk(OP_ADD, 2, 0, 32'hFFFF_FFFF, 0, 0), 1,
			rs(ST_OK, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5)});
		plan.insert(plan.size(), '{mk(OP_ADD, 2, 3, 32'h0001_0000, 1, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_ADD, 2, 6, 32'h0001_0000, 1, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_ADD, 2, 60, 32'h8000_0000, 0, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_READ, 2, 0, 0, 0, 1), 0, nil});
		plan.insert(plan.size(), '{mk(OP_READ, 1, 0, 0, 0, 0), 0, nil});
		plan.insert(plan.size(), '{mk(OP_ADD, 3, 7, 1, 1, 0), 1, rs(ST_BAD_CH, 0, 0, 0, 0)});

		write_reg(CFG_PERIOD, 5);
		write_reg(CFG_ACTIVE, 3);
		foreach (plan[i]) send_beat(plan[i].req, plan[i].typed, plan[i].rsp);
		drain();

		// random part, one phase per register setting
		for (int ph = 0; ph < 7; ph++) begin
			int n;
			case (ph)
				0: begin write_reg(CFG_PERIOD, 0); write_reg(CFG_ACTIVE, 7); end
				1: begin write_reg(CFG_PERIOD, 32'hFFFF_FFFF); write_reg(CFG_ACTIVE, 4); end
				2: begin write_reg(CFG_PERIOD, 3); write_reg(CFG_ACTIVE, 0); end
				3: begin write_reg(CFG_PERIOD, 1); write_reg(CFG_ACTIVE, 1); end
				4: begin write_reg(CFG_PERIOD, 32'h8000_0001); write_reg(CFG_ACTIVE, 2); end
				5: begin write_reg(CFG_PERIOD, 7); write_reg(CFG_ACTIVE, 4); end
				default: begin write_reg(CFG_PERIOD, 2); write_reg(CFG_ACTIVE, 5); end
			endcase
			n = (ph == 2) ? 15 : 70;
			for (int i = 0; i < n; i++) begin
				if (i % 25 == 0) calm = (ph % 2 == 1) && (i == 25);
				send_beat(random_req(), 0, nil);
			end
			calm = 0;
			drain();
		end

		$display("%0d adds and %0d reads, %0d result beats, %0d compactions",
			adds_sent, reads_sent, beats_out, decimations);
		$display("register writes swept the first-point period and 0..7 active channels");
		if (errors == 0 && pending_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

// File: files.f
sv/dwc_pkg.sv
sv/dwc_ram.sv
sv/dwc_div.sv
sv/decimating_waveform_capture.sv
bench/tb_top.sv
